/* design/hned_pkg.sv */
// Shared codes, constants and types for the HMM next-emission distribution core.
`default_nettype none

package hned_pkg;

  localparam int PROB_W = 16;
  localparam logic [PROB_W-1:0] QONE = 16'h8000;

  localparam logic [1:0] OP_LOAD_A  = 2'd0;
  localparam logic [1:0] OP_LOAD_B  = 2'd1;
  localparam logic [1:0] OP_LOAD_PI = 2'd2;
  localparam logic [1:0] OP_COMPUTE = 2'd3;

  localparam logic [1:0] CFG_NUM_STATES  = 2'd0;
  localparam logic [1:0] CFG_NUM_SYMBOLS = 2'd1;
  localparam logic [1:0] CFG_DIST_ROWS   = 2'd2;

  typedef struct packed {
    logic valid;
    logic phase;
    logic first;
    logic last;
    logic tail;
  } hned_tag_t;

endpackage

`default_nettype wire

/* design/hned_mem.sv */
// Matrix stores for A, B, pi and the intermediate distribution D, with registered reads.
`default_nettype none

module hned_mem import hned_pkg::*; #(
  parameter int MAX_STATES    = 16,
  parameter int MAX_SYMBOLS   = 16,
  parameter int MAX_DIST_ROWS = 4,
  parameter int RW            = 2,
  parameter int CNT_W         = 5
) (
  input  wire logic              clk_i,
  input  wire logic              ld_en_i,
  input  wire logic [1:0]        ld_op_i,
  input  wire logic [3:0]        ld_row_i,
  input  wire logic [3:0]        ld_col_i,
  input  wire logic [PROB_W-1:0] ld_val_i,
  input  wire logic              dw_en_i,
  input  wire logic [RW-1:0]     dw_row_i,
  input  wire logic [CNT_W-1:0]  dw_col_i,
  input  wire logic [PROB_W-1:0] dw_val_i,
  input  wire logic              rd_phase_i,
  input  wire logic [RW-1:0]     rd_row_i,
  input  wire logic [CNT_W-1:0]  rd_col_i,
  input  wire logic [$clog2(MAX_STATES)-1:0] rd_k_i,
  output logic      [PROB_W-1:0] opa_o,
  output logic      [PROB_W-1:0] opb_o
);

  localparam int SW = $clog2(MAX_STATES);
  localparam int YW = $clog2(MAX_SYMBOLS);

  logic [PROB_W-1:0] trans_mem [MAX_STATES][MAX_STATES];
  logic [PROB_W-1:0] emis_mem  [MAX_STATES][MAX_SYMBOLS];
  logic [PROB_W-1:0] init_mem  [MAX_DIST_ROWS][MAX_STATES];
  logic [PROB_W-1:0] dist_mem  [MAX_DIST_ROWS][MAX_STATES];

  logic [PROB_W-1:0] trans_rd_q, emis_rd_q, init_rd_q, dist_rd_q;
  logic              phase_q;
  logic              row_in_a, col_in_a, col_in_b, row_in_pi;

  assign row_in_a  = 32'(ld_row_i) < MAX_STATES;
  assign col_in_a  = 32'(ld_col_i) < MAX_STATES;
  assign col_in_b  = 32'(ld_col_i) < MAX_SYMBOLS;
  assign row_in_pi = 32'(ld_row_i) < MAX_DIST_ROWS;

  always_ff @(posedge clk_i) begin
    if (ld_en_i && ld_op_i == OP_LOAD_A && row_in_a && col_in_a) begin
      trans_mem[SW'(ld_row_i)][SW'(ld_col_i)] <= ld_val_i;
    end
    trans_rd_q <= trans_mem[rd_k_i][SW'(rd_col_i)];
  end

  always_ff @(posedge clk_i) begin
    if (ld_en_i && ld_op_i == OP_LOAD_B && row_in_a && col_in_b) begin
      emis_mem[SW'(ld_row_i)][YW'(ld_col_i)] <= ld_val_i;
    end
    emis_rd_q <= emis_mem[rd_k_i][YW'(rd_col_i)];
  end

  always_ff @(posedge clk_i) begin
    if (ld_en_i && ld_op_i == OP_LOAD_PI && row_in_pi && col_in_a) begin
      init_mem[RW'(ld_row_i)][SW'(ld_col_i)] <= ld_val_i;
    end
    init_rd_q <= init_mem[rd_row_i][rd_k_i];
  end

  always_ff @(posedge clk_i) begin
    if (dw_en_i) begin
      dist_mem[dw_row_i][SW'(dw_col_i)] <= dw_val_i;
    end
    dist_rd_q <= dist_mem[rd_row_i][rd_k_i];
  end

  always_ff @(posedge clk_i) begin
    phase_q <= rd_phase_i;
  end

  assign opa_o = phase_q ? dist_rd_q : init_rd_q;
  assign opb_o = phase_q ? emis_rd_q : trans_rd_q;

endmodule

`default_nettype wire

/* design/hned_seq.sv */
// Loop sequencer that walks the two matrix products one multiply-accumulate per cycle, with a drain between.
`default_nettype none

module hned_seq import hned_pkg::*; #(
  parameter int MAX_STATES = 16,
  parameter int RW         = 2,
  parameter int CNT_W      = 5
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             go_i,
  input  wire logic [CNT_W-1:0] ns_i,
  input  wire logic [CNT_W-1:0] nsym_i,
  input  wire logic [CNT_W-1:0] nr_i,
  output logic                  busy_o,
  output hned_tag_t             tag_o,
  output logic      [RW-1:0]    row_o,
  output logic      [CNT_W-1:0] col_o,
  output logic      [$clog2(MAX_STATES)-1:0] k_o
);

  localparam int SW = $clog2(MAX_STATES);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_P1    = 3'd1;
  localparam logic [2:0] S_DRAIN = 3'd2;
  localparam logic [2:0] S_P2    = 3'd3;

  localparam logic [1:0] DRAIN_CYC = 2'd3;

  logic [2:0]       state_q, state_d;
  logic [RW-1:0]    i_q, i_d;
  logic [CNT_W-1:0] j_q, j_d;
  logic [SW-1:0]    k_q, k_d;
  logic [1:0]       drain_q, drain_d;
  logic [CNT_W-1:0] j_lim;
  logic             issuing, k_end, j_end, i_end;

  assign issuing = (state_q == S_P1) || (state_q == S_P2);
  assign j_lim   = (state_q == S_P2) ? nsym_i : ns_i;
  assign k_end   = (CNT_W'(k_q) + CNT_W'(1)) == ns_i;
  assign j_end   = (j_q + CNT_W'(1)) == j_lim;
  assign i_end   = (CNT_W'(i_q) + CNT_W'(1)) == nr_i;

  always_comb begin
    state_d = state_q;
    i_d     = i_q;
    j_d     = j_q;
    k_d     = k_q;
    drain_d = drain_q;
    unique case (state_q)
      S_IDLE: begin
        if (go_i) begin
          state_d = S_P1;
          i_d     = '0;
          j_d     = '0;
          k_d     = '0;
        end
      end
      S_P1, S_P2: begin
        if (!k_end) begin
          k_d = k_q + SW'(1);
        end else begin
          k_d = '0;
          if (!j_end) begin
            j_d = j_q + CNT_W'(1);
          end else begin
            j_d = '0;
            if (!i_end) begin
              i_d = i_q + RW'(1);
            end else begin
              i_d = '0;
              if (state_q == S_P1) begin
                state_d = S_DRAIN;
                drain_d = DRAIN_CYC;
              end else begin
                state_d = S_IDLE;
              end
            end
          end
        end
      end
      S_DRAIN: begin
        if (drain_q == 2'd0) begin
          state_d = S_P2;
        end else begin
          drain_d = drain_q - 2'd1;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      i_q     <= '0;
      j_q     <= '0;
      k_q     <= '0;
      drain_q <= '0;
    end else begin
      state_q <= state_d;
      i_q     <= i_d;
      j_q     <= j_d;
      k_q     <= k_d;
      drain_q <= drain_d;
    end
  end

  assign busy_o      = state_q != S_IDLE;
  assign tag_o.valid = issuing;
  assign tag_o.phase = state_q == S_P2;
  assign tag_o.first = k_q == '0;
  assign tag_o.last  = k_end;
  assign tag_o.tail  = (state_q == S_P2) && k_end && j_end && i_end;
  assign row_o       = i_q;
  assign col_o       = j_q;
  assign k_o         = k_q;

  a_p2_after_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_P2 && $past(state_q) != S_P2) |-> $past(state_q) == S_DRAIN)
    else $error("second product started without draining the first");

  a_drain_to_p2: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DRAIN && drain_q == 2'd0) |=> state_q == S_P2)
    else $error("drain did not hand over to the second product");

endmodule

`default_nettype wire

/* design/hned_mac.sv */
// Shared multiply-accumulate unit with Q1.15 truncation and saturation at 1.0.
`default_nettype none

module hned_mac import hned_pkg::*; #(
  parameter int MAX_STATES = 16,
  parameter int RW         = 2,
  parameter int CNT_W      = 5
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire hned_tag_t         tag_i,
  input  wire logic [RW-1:0]     row_i,
  input  wire logic [CNT_W-1:0]  col_i,
  input  wire logic [PROB_W-1:0] opa_i,
  input  wire logic [PROB_W-1:0] opb_i,
  output hned_tag_t              res_tag_o,
  output logic      [RW-1:0]     res_row_o,
  output logic      [CNT_W-1:0]  res_col_o,
  output logic      [PROB_W-1:0] res_val_o
);

  localparam int PW = 2 * PROB_W;
  localparam int AW = PW + $clog2(MAX_STATES);
  localparam int FW = AW - 15;

  hned_tag_t         tag1_q, tag2_q, tag3_q, res_tag_q, res_tag_d;
  logic [RW-1:0]     row1_q, row2_q, row3_q, res_row_q;
  logic [CNT_W-1:0]  col1_q, col2_q, col3_q, res_col_q;
  logic [PW-1:0]     prod_q;
  logic [AW-1:0]     acc_q, acc_d;
  logic [FW-1:0]     shifted;
  logic [PROB_W-1:0] res_val_q, res_val_d;

  assign acc_d   = tag2_q.first ? AW'(prod_q) : acc_q + AW'(prod_q);
  assign shifted = acc_q[AW-1:15];
  assign res_val_d = (shifted > FW'(QONE)) ? QONE : shifted[PROB_W-1:0];

  always_comb begin
    res_tag_d       = tag3_q;
    res_tag_d.valid = tag3_q.valid && tag3_q.last;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag1_q    <= '0;
      tag2_q    <= '0;
      tag3_q    <= '0;
      res_tag_q <= '0;
    end else begin
      tag1_q    <= tag_i;
      tag2_q    <= tag1_q;
      tag3_q    <= tag2_q;
      res_tag_q <= res_tag_d;
    end
  end

  always_ff @(posedge clk_i) begin
    row1_q    <= row_i;
    col1_q    <= col_i;
    row2_q    <= row1_q;
    col2_q    <= col1_q;
    prod_q    <= opa_i * opb_i;
    row3_q    <= row2_q;
    col3_q    <= col2_q;
    if (tag2_q.valid) begin
      acc_q <= acc_d;
    end
    res_row_q <= row3_q;
    res_col_q <= col3_q;
    res_val_q <= res_val_d;
  end

  assign res_tag_o = res_tag_q;
  assign res_row_o = res_row_q;
  assign res_col_o = res_col_q;
  assign res_val_o = res_val_q;

  a_tail_in_second: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_tag_q.valid && res_tag_q.tail) |-> res_tag_q.phase)
    else $error("final item flagged outside the emission product");

  a_sum_starts_fresh: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (tag3_q.valid && tag3_q.last && !tag3_q.first) |-> $past(tag2_q.valid))
    else $error("multi-term sum finished without a preceding term");

endmodule

`default_nettype wire

/* design/hmm_next_emission_distribution_core.sv */
// Top level of the HMM next-emission distribution core: config, stores, sequencer and MAC.
//
//  Channel   Ports                                              Handshake
//  -------   -------------------------------------------------  ------------------------------
//  command   start_i, operation_i, row_index_i, col_index_i,     taken when start_i && !busy_o
//            prob_value_i, busy_o
//  result    out_valid_o, out_row_o, out_col_o, out_prob_o,      no stall
//            last_o
//  config    cfg_we_i, cfg_index_i, cfg_data_i                   written when cfg_we_i is high
//
//  A load item leaves busy_o low.
//  A compute item holds busy_o high while the sequencer walks both products over the
//  distribution rows, states and symbols in use: one multiply-accumulate per cycle on the
//  single multiplier, with a drain between the two products.
//  The last result item reaches the ports after busy_o has gone low.
//  Reset clears control state and sets the registers to 4 states, 4 symbols and 1 row.
//  Results cannot be held off by the receiver.
`default_nettype none

module hmm_next_emission_distribution_core import hned_pkg::*; #(
  parameter int MAX_STATES    = 16,
  parameter int MAX_SYMBOLS   = 16,
  parameter int MAX_DIST_ROWS = 4
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  output logic                   busy_o,
  input  wire logic [1:0]        operation_i,
  input  wire logic [3:0]        row_index_i,
  input  wire logic [3:0]        col_index_i,
  input  wire logic [PROB_W-1:0] prob_value_i,
  output logic                   out_valid_o,
  output logic      [1:0]        out_row_o,
  output logic      [3:0]        out_col_o,
  output logic      [PROB_W-1:0] out_prob_o,
  output logic                   last_o,
  input  wire logic              cfg_we_i,
  input  wire logic [1:0]        cfg_index_i,
  input  wire logic [4:0]        cfg_data_i
);

  localparam int SW      = $clog2(MAX_STATES);
  localparam int RW      = (MAX_DIST_ROWS > 1) ? $clog2(MAX_DIST_ROWS) : 1;
  localparam int CNT_W   = $clog2(((MAX_STATES > 16) ? MAX_STATES : 16) + 1);
  localparam int SYM_CAP = (MAX_SYMBOLS < 16) ? MAX_SYMBOLS : 16;
  localparam int ROW_CAP = (MAX_DIST_ROWS < 4) ? MAX_DIST_ROWS : 4;

  logic [4:0]        num_states_q, num_symbols_q;
  logic [2:0]        dist_rows_q;
  logic [CNT_W-1:0]  ns, nsym, nr;
  logic              accept, go, ld_en;
  hned_tag_t         tag, res_tag;
  logic [RW-1:0]     seq_row, res_row;
  logic [CNT_W-1:0]  seq_col, res_col;
  logic [SW-1:0]     seq_k;
  logic [PROB_W-1:0] opa, opb, res_val;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_states_q  <= 5'd4;
      num_symbols_q <= 5'd4;
      dist_rows_q   <= 3'd1;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_NUM_STATES:  num_states_q  <= cfg_data_i;
        CFG_NUM_SYMBOLS: num_symbols_q <= cfg_data_i;
        CFG_DIST_ROWS:   dist_rows_q   <= cfg_data_i[2:0];
        default: ;
      endcase
    end
  end

  assign ns   = (num_states_q == '0) ? CNT_W'(1) :
                (CNT_W'(num_states_q) > CNT_W'(MAX_STATES)) ? CNT_W'(MAX_STATES) :
                CNT_W'(num_states_q);
  assign nsym = (num_symbols_q == '0) ? CNT_W'(1) :
                (CNT_W'(num_symbols_q) > CNT_W'(SYM_CAP)) ? CNT_W'(SYM_CAP) :
                CNT_W'(num_symbols_q);
  assign nr   = (dist_rows_q == '0) ? CNT_W'(1) :
                (CNT_W'(dist_rows_q) > CNT_W'(ROW_CAP)) ? CNT_W'(ROW_CAP) :
                CNT_W'(dist_rows_q);

  assign accept = start_i && !busy_o;
  assign go     = accept && operation_i == OP_COMPUTE;
  assign ld_en  = accept && operation_i != OP_COMPUTE;

  hned_seq #(
    .MAX_STATES (MAX_STATES),
    .RW         (RW),
    .CNT_W      (CNT_W)
  ) u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .go_i   (go),
    .ns_i   (ns),
    .nsym_i (nsym),
    .nr_i   (nr),
    .busy_o (busy_o),
    .tag_o  (tag),
    .row_o  (seq_row),
    .col_o  (seq_col),
    .k_o    (seq_k)
  );

  hned_mem #(
    .MAX_STATES    (MAX_STATES),
    .MAX_SYMBOLS   (MAX_SYMBOLS),
    .MAX_DIST_ROWS (MAX_DIST_ROWS),
    .RW            (RW),
    .CNT_W         (CNT_W)
  ) u_mem (
    .clk_i      (clk_i),
    .ld_en_i    (ld_en),
    .ld_op_i    (operation_i),
    .ld_row_i   (row_index_i),
    .ld_col_i   (col_index_i),
    .ld_val_i   (prob_value_i),
    .dw_en_i    (res_tag.valid && !res_tag.phase),
    .dw_row_i   (res_row),
    .dw_col_i   (res_col),
    .dw_val_i   (res_val),
    .rd_phase_i (tag.phase),
    .rd_row_i   (seq_row),
    .rd_col_i   (seq_col),
    .rd_k_i     (seq_k),
    .opa_o      (opa),
    .opb_o      (opb)
  );

  hned_mac #(
    .MAX_STATES (MAX_STATES),
    .RW         (RW),
    .CNT_W      (CNT_W)
  ) u_mac (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .tag_i     (tag),
    .row_i     (seq_row),
    .col_i     (seq_col),
    .opa_i     (opa),
    .opb_i     (opb),
    .res_tag_o (res_tag),
    .res_row_o (res_row),
    .res_col_o (res_col),
    .res_val_o (res_val)
  );

  assign out_valid_o = res_tag.valid && res_tag.phase;
  assign out_row_o   = 2'(res_row);
  assign out_col_o   = 4'(res_col);
  assign out_prob_o  = res_val;
  assign last_o      = out_valid_o && res_tag.tail;

  a_busy_from_compute: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy_o) |-> $past(start_i && operation_i == OP_COMPUTE))
    else $error("core went busy without a compute item");

  a_gap_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && last_o) |=> !out_valid_o)
    else $error("result item followed the final item directly");

endmodule

`default_nettype wire
